// File: rtl/slot_id_pool_allocator_defines.svh
// Assertion macros shared by the slot allocator checker.
`ifndef SLOT_ID_POOL_ALLOCATOR_DEFINES_SVH
`define SLOT_ID_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SLIP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SLIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator assertion failed");

`endif

// File: rtl/slip_pkg.sv
// Shared constants and types of the slot ID pool allocator.
`timescale 1ns / 1ps

package slip_pkg;

    // Field widths
    localparam int REQ_W = 2;
    localparam int ID_W  = 8;
    localparam int CNT_W = 9;

    // Largest id space the 8-bit slot field can address
    localparam int ID_SPACE = 256;

    // Default pool depth
    localparam int DEF_MAX_SLOTS = 256;

    // Reset value of the capacity register
    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_NOT_USED = 2'd3;

    // Control group from the sequencer to the bitmap store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_data;
    } map_cmd_t;

endpackage

// File: rtl/slip_map.sv
// Used-bitmap store: one-bit memory with per-entry valid flags and a registered read.
`timescale 1ns / 1ps

module slip_map import slip_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_SLOTS,
    parameter int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  map_cmd_t         cmd,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic [IDX_W-1:0] wr_addr,
    output logic             rd_used
);

    logic             used_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic             rd_mem_reg;
    logic             rd_valid_reg;
    logic             rd_zero_reg;

    // Mark an entry written; unwritten entries read as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Write the bit and register the read word
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            used_mem[wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_mem_reg   <= used_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            rd_zero_reg  <= (rd_addr == '0);
        end
    end

    // Slot zero is always live
    assign rd_used = rd_zero_reg | (rd_valid_reg & rd_mem_reg);

endmodule

// File: rtl/slip_step.sv
// Step unit: advance a slot candidate by one, wrapping to slot one at capacity.
`timescale 1ns / 1ps

module slip_step import slip_pkg::*;
(
    input  logic [CNT_W-1:0] cur,
    input  logic [CNT_W-1:0] cap,
    output logic [CNT_W-1:0] nxt
);

    logic [CNT_W-1:0] sum;

    // Increment, then wrap past the top of the pool
    assign sum = cur + CNT_W'(1);
    assign nxt = (sum >= cap) ? CNT_W'(1) : sum;

endmodule

// File: rtl/slot_id_pool_allocator.sv
// Top level of the slot ID pool allocator: sequencer, registers and ports.
`timescale 1ns / 1ps
//
// Slot ID pool allocator over a used-bitmap, slot zero reserved.
// Input words arrive on the s_ channel: s_tuser carries the request kind
// (allocate, free, check) and s_tdata the slot id. One result word per
// request leaves on the m_ channel: m_tuser carries the status, m_tdata the
// result id and the used count after the request.
// Free and check pass from acceptance through S_START, a bitmap read in
// S_EVAL and S_FINISH into the output register behind m_tvalid; rejected
// requests (full pool, bad id, unknown kind) skip S_EVAL. An allocate stays
// in S_EVAL while it probes slots from the search hint (1 up to the capacity
// less one), one bitmap read per cycle through the step unit. s_tready is high
// only while the sequencer is idle, so one request is in work at a time.
// The result sits in an output register: the next request is accepted
// while it waits, and when m_tready is low the finished result of that next
// request holds until the register frees up.
// Reset clears the bitmap (per-entry valid flags clear at once, no sweep),
// sets the used count and hint to one and the capacity register to 256.
// pool_capacity is written over APB at address 0; the user must write it
// only while the block is idle, as the block itself does not enforce this.

module slot_id_pool_allocator import slip_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] slot_id
    input  logic [1:0]  s_tuser,    // [1:0] req_type
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] result_id, [16:8] used_count, [23:17] zero
    output logic [1:0]  m_tuser,    // [1:0] status
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MAP_DEPTH = (MAX_SLOTS < ID_SPACE) ? MAX_SLOTS : ID_SPACE;
    localparam int IDX_W     = $clog2(MAP_DEPTH);
    localparam logic [2:0] ADDR_CAP = 3'd0;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_START  = 4'b0010,
        S_EVAL   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [REQ_W-1:0] req_reg;
    logic [ID_W-1:0]  id_reg;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] hint_reg, hint_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] cap_reg;
    logic [1:0]       res_status_reg, res_status_next;
    logic [ID_W-1:0]  res_id_reg, res_id_next;
    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] start_slot;
    logic [CNT_W-1:0] step_nxt;
    logic [CNT_W-1:0] id_ext;
    logic             in_fire;
    logic             out_load;
    logic             cfg_write;
    logic             rd_used;
    map_cmd_t         map_cmd;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    // Handshakes
    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || m_tready);
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_CAP);

    // Effective capacity and search start
    assign cap_eff    = (cap_reg > CNT_W'(MAP_DEPTH)) ? CNT_W'(MAP_DEPTH) : cap_reg;
    assign start_slot = (hint_reg == '0 || hint_reg >= cap_eff) ? CNT_W'(1) : hint_reg;
    assign id_ext     = {1'b0, id_reg};

    // Step unit of the allocate search
    slip_step u_step (
        .cur (cur_reg),
        .cap (cap_eff),
        .nxt (step_nxt)
    );

    // Bitmap store
    slip_map #(
        .DEPTH (MAP_DEPTH),
        .IDX_W (IDX_W)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (map_cmd),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .rd_used (rd_used)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        hint_next       = hint_reg;
        total_next      = total_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        map_cmd         = '0;
        rd_addr         = id_reg[IDX_W-1:0];
        wr_addr         = id_reg[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                res_status_next = ST_INVALID;
                res_id_next     = '0;
                state_next      = S_FINISH;
                case (req_reg)
                    REQ_ALLOC:
                    begin
                        if (total_reg >= cap_eff)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            cur_next      = start_slot;
                            rd_addr       = start_slot[IDX_W-1:0];
                            map_cmd.rd_en = 1'b1;
                            state_next    = S_EVAL;
                        end
                    end
                    REQ_FREE:
                    begin
                        if (id_reg != '0 && id_ext < cap_eff)
                        begin
                            map_cmd.rd_en = 1'b1;
                            state_next    = S_EVAL;
                        end
                    end
                    REQ_CHECK:
                    begin
                        if (id_ext < cap_eff)
                        begin
                            map_cmd.rd_en = 1'b1;
                            state_next    = S_EVAL;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_INVALID;
                    end
                endcase
            end
            S_EVAL:
            begin
                state_next = S_FINISH;
                case (req_reg)
                    REQ_ALLOC:
                    begin
                        if (rd_used)
                        begin
                            // Probe the next slot, data back next cycle
                            cur_next      = step_nxt;
                            rd_addr       = step_nxt[IDX_W-1:0];
                            map_cmd.rd_en = 1'b1;
                            state_next    = S_EVAL;
                        end
                        else
                        begin
                            wr_addr         = cur_reg[IDX_W-1:0];
                            map_cmd.wr_en   = 1'b1;
                            map_cmd.wr_data = 1'b1;
                            total_next      = total_reg + CNT_W'(1);
                            hint_next       = cur_reg + CNT_W'(1);
                            res_status_next = ST_OK;
                            res_id_next     = cur_reg[ID_W-1:0];
                        end
                    end
                    REQ_FREE:
                    begin
                        if (rd_used)
                        begin
                            map_cmd.wr_en   = 1'b1;
                            map_cmd.wr_data = 1'b0;
                            if (total_reg != '0)
                            begin
                                total_next = total_reg - CNT_W'(1);
                            end
                            if (id_ext < hint_reg)
                            begin
                                hint_next = id_ext;
                            end
                            res_status_next = ST_OK;
                            res_id_next     = id_reg;
                        end
                        else
                        begin
                            res_status_next = ST_NOT_USED;
                            res_id_next     = '0;
                        end
                    end
                    default:
                    begin
                        // Check of a slot in range
                        res_status_next = rd_used ? ST_OK : ST_NOT_USED;
                        res_id_next     = rd_used ? id_reg : '0;
                    end
                endcase
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hint_reg      <= CNT_W'(1);
            total_reg     <= CNT_W'(1);
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hint_reg  <= hint_next;
            total_reg <= total_next;
            if (cfg_write)
            begin
                cap_reg <= pwdata[CNT_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= s_tuser;
            id_reg  <= s_tdata;
        end
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_count_reg  <= total_reg;
        end
    end

    // Result word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_id_reg};

    // Register read back
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAP) ? {23'd0, cap_reg} : 32'd0;

endmodule

// File: rtl/slip_checker.sv
// Port-level assertions of the slot ID pool allocator, bound to the top level.
`timescale 1ns / 1ps
`include "slot_id_pool_allocator_defines.svh"

module slip_checker import slip_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result word holds
    `SLIP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // A failed request reports id zero
    `SLIP_ASSERT_NOW(a_fail_id_zero, m_tvalid && m_tuser != ST_OK, m_tdata[7:0] == 8'd0)

    // Used count stays within one and the id space
    `SLIP_ASSERT_NOW(a_count_range, m_tvalid, m_tdata[16:8] != 9'd0 && m_tdata[16:8] <= 9'd256)

    // Busy right after a request is taken
    `SLIP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

bind slot_id_pool_allocator slip_checker u_slip_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
